/* sv/diff_drive_track_odometry_step_core_assert.svh */
// assertion macros for the checker file
// depends on nothing; include once per file that asserts
`ifndef DIFF_DRIVE_TRACK_ODOMETRY_STEP_CORE_ASSERT_SVH
`define DIFF_DRIVE_TRACK_ODOMETRY_STEP_CORE_ASSERT_SVH

// same-cycle implication
`define DDO_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: label");

// next-cycle implication
`define DDO_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: label");

`endif

/* sv/ddo_pkg.sv */
// shared types, constants and table builder for the odometry step core
// depends on nothing
`timescale 1ns / 1ps
package ddo_pkg;

   localparam int unsigned TWO_PI_Q16 = 411775;
   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
   localparam int unsigned MUL_A_W = 48;
   localparam int unsigned MUL_B_W = 18;
   localparam int unsigned MUL_P_W = 64;
   localparam int unsigned DIV_N_W = 36;
   localparam int unsigned DIV_R_W = 19;

   typedef enum logic [1:0] {
      CSR_LINEAR_SPEED = 2'd0,
      CSR_STEER_GAIN   = 2'd1,
      CSR_WHEEL_BASE   = 2'd2,
      CSR_PULSE_GAIN   = 2'd3
   } csr_idx_type;

   localparam longint unsigned SERIES_DIV [0:5] = '{6, 20, 42, 72, 110, 156};

   // sin(j * (pi/2) / 2^qbits) in q1.15, taylor series in q30
   function automatic logic [15:0] quarter_sin(input int unsigned j, input int unsigned qbits);
      longint unsigned a;
      longint unsigned a2;
      longint unsigned term;
      longint sum;
      a = (longint'(j) * HALF_PI_Q30) >> qbits;
      a2 = (a * a) >> 30;
      term = a;
      sum = longint'(a);
      for (int n = 1; n <= 6; n++) begin
         term = ((term * a2) >> 30) / SERIES_DIV[n-1];
         if (n % 2 == 1) sum = sum - longint'(term);
         else sum = sum + longint'(term);
      end
      if (sum < 0) sum = 0;
      if (sum > (64'sd1 <<< 30)) sum = 64'sd1 <<< 30;
      return 16'((sum + 64'sd16384) >>> 15);
   endfunction

   // arithmetic shift right with round half up
   function automatic logic signed [63:0] rnd_shr(input logic signed [63:0] x,
                                                  input int unsigned n);
      return (x + (64'sd1 <<< (n - 1))) >>> n;
   endfunction

endpackage

/* sv/ddo_chan_if.sv */
// valid/ready channel interfaces for step requests and wheel responses
// depends on nothing
`timescale 1ns / 1ps
interface ddo_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] step_time;
   modport source (output valid, output step_time, input ready);
   modport sink (input valid, input step_time, output ready);
endinterface

interface ddo_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] left_speed;
   logic signed [15:0] right_speed;
   logic               clipped;
   modport source (output valid, output left_speed, output right_speed, output clipped,
                   input ready);
   modport sink (input valid, input left_speed, input right_speed, input clipped,
                 output ready);
endinterface

/* sv/diff_drive_track_odometry_step_core.sv */
// differential drive odometry step core: top level with sequencer and pose state
// depends on ddo_pkg, ddo_chan_if, ddo_smul, ddo_sdiv
//
// channel  dir  word fields                          handshake
// req_port in   step_time                            valid/ready
// rsp_port out  left_speed, right_speed, clipped     valid/ready
// csr_*    in   csr_index, csr_wdata                 csr_we, no wait
//
// each word runs two passes of the serial divider (table index and heading
// wrap) and thirteen serial multiplies, with sequencing and table reads
// between them
// a new step word is taken whenever the sequencer is idle, even with a response
// still waiting; the final state waits for the response register to be free
// reset is synchronous: pose clears to zero, registers take their defaults
`timescale 1ns / 1ps
module diff_drive_track_odometry_step_core
   import ddo_pkg::*;
#(
   parameter int unsigned TRIG_TABLE_BITS = 10
) (
   input  logic            clock,
   input  logic            reset,
   ddo_req_if.sink         req_port,
   ddo_rsp_if.source       rsp_port,
   input  logic            csr_we,
   input  logic [1:0]      csr_index,
   input  logic [15:0]     csr_wdata
);
   localparam int unsigned TB = TRIG_TABLE_BITS;
   localparam int unsigned QTR = 1 << (TB - 2);

   typedef enum logic [3:0] {
      ST_IDLE, ST_IDXGO, ST_IDX, ST_SIN, ST_COS, ST_CSW, ST_MUL, ST_MODGO, ST_MOD, ST_OUT
   } st_type;

   typedef enum logic [3:0] {
      OP_DXC, OP_DYS, OP_KP, OP_WB, OP_L1, OP_L2, OP_R1, OP_R2,
      OP_XC, OP_XD, OP_YS, OP_YD, OP_WD
   } op_type;

   // quarter-wave sine table, folded by quadrant
   logic [15:0] qtab [0:QTR];
   for (genvar g = 0; g <= QTR; g++) begin : g_qtab
      assign qtab[g] = quarter_sin(g, TB - 2);
   end

   st_type state_ff, state_in;
   op_type op_ff, op_in;

   logic signed [15:0] lin_ff, lin_in, kgain_ff, kgain_in;
   logic [15:0] base_ff, base_in, gain_ff, gain_in, dt_ff, dt_in;
   logic signed [23:0] pos_x_ff, pos_x_in, pos_y_ff, pos_y_in;
   logic [19:0] head_ff, head_in;
   logic [TB-1:0] idx_ff, idx_in;
   logic signed [16:0] sn_ff, sn_in, cs_ff, cs_in;
   logic signed [63:0] t1_ff, t1_in;
   logic signed [27:0] proj_ff, proj_in;
   logic signed [33:0] w_ff, w_in;
   logic signed [34:0] vl_ff, vl_in, vr_ff, vr_in;
   logic signed [15:0] lw_ff, lw_in, rw_ff, rw_in;
   logic clw_ff, clw_in;
   logic [35:0] hmag_ff, hmag_in;
   logic hneg_ff, hneg_in;
   logic [15:0] rom_ff;
   logic rom_neg_ff;
   logic mul_go_ff, mul_go_in, div_go_ff, div_go_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic signed [15:0] ro_left_ff, ro_left_in, ro_right_ff, ro_right_in;
   logic ro_clip_ff, ro_clip_in;

   // table read port
   logic [TB-1:0] rom_idx;
   logic [TB-2:0] rom_j;
   logic signed [16:0] rom_val;

   // serial unit hookup
   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic mul_done, div_done;
   logic signed [MUL_P_W-1:0] mul_p;
   logic [DIV_N_W-1:0] div_num, div_quo;
   logic [DIV_R_W-1:0] div_rem;

   // datapath temporaries
   logic signed [24:0] dx, dy;
   logic signed [63:0] v33, sum64, cmd, pos_sum, hsum, rnd_v;
   logic signed [15:0] sat16;
   logic sat_hit;

   ddo_smul u_mul (
      .clock(clock), .reset(reset), .go(mul_go_ff), .a(mul_a), .b(mul_b),
      .done(mul_done), .p(mul_p)
   );

   ddo_sdiv u_div (
      .clock(clock), .reset(reset), .go(div_go_ff), .num(div_num),
      .done(div_done), .quo(div_quo), .rem(div_rem)
   );

   assign div_num = (state_ff == ST_MOD) ? DIV_N_W'(hmag_ff)
                                         : DIV_N_W'({head_ff, {TB{1'b0}}});

   // sine at idx in the sin state, cosine (quarter turn ahead) otherwise
   assign rom_idx = (state_ff == ST_SIN) ? idx_ff : idx_ff + TB'(QTR);
   assign rom_j = rom_idx[TB-2] ? (TB-1)'(QTR) - {1'b0, rom_idx[TB-3:0]}
                                : {1'b0, rom_idx[TB-3:0]};
   assign rom_val = rom_neg_ff ? -$signed({1'b0, rom_ff}) : $signed({1'b0, rom_ff});

   assign dx = {pos_x_ff[23], pos_x_ff} - 25'sd65536;
   assign dy = {pos_y_ff[23], pos_y_ff} - 25'sd65536;
   assign v33 = 64'(lin_ff) <<< 21;

   // operand selection per micro-op
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (op_ff)
         OP_DXC: begin mul_a = MUL_A_W'(dx);      mul_b = MUL_B_W'(cs_ff); end
         OP_DYS: begin mul_a = MUL_A_W'(dy);      mul_b = MUL_B_W'(sn_ff); end
         OP_KP:  begin mul_a = MUL_A_W'(proj_ff); mul_b = MUL_B_W'(kgain_ff); end
         OP_WB:  begin mul_a = MUL_A_W'(w_ff);    mul_b = $signed({2'b00, base_ff}); end
         OP_L1:  begin mul_a = MUL_A_W'(vl_ff);   mul_b = 18'sd1000; end
         OP_L2:  begin mul_a = t1_ff[MUL_A_W-1:0]; mul_b = $signed({2'b00, gain_ff}); end
         OP_R1:  begin mul_a = MUL_A_W'(vr_ff);   mul_b = 18'sd1000; end
         OP_R2:  begin mul_a = t1_ff[MUL_A_W-1:0]; mul_b = $signed({2'b00, gain_ff}); end
         OP_XC:  begin mul_a = MUL_A_W'(cs_ff);   mul_b = MUL_B_W'(lin_ff); end
         OP_XD:  begin mul_a = t1_ff[MUL_A_W-1:0]; mul_b = $signed({2'b00, dt_ff}); end
         OP_YS:  begin mul_a = MUL_A_W'(sn_ff);   mul_b = MUL_B_W'(lin_ff); end
         OP_YD:  begin mul_a = t1_ff[MUL_A_W-1:0]; mul_b = $signed({2'b00, dt_ff}); end
         OP_WD:  begin mul_a = MUL_A_W'(w_ff);    mul_b = $signed({2'b00, dt_ff}); end
         default: begin mul_a = '0; mul_b = '0; end
      endcase
   end

   // wheel command rounding and saturation
   always_comb begin
      cmd = rnd_shr(mul_p, 28);
      sat_hit = 1'b0;
      sat16 = cmd[15:0];
      if (cmd > 64'sd32767) begin
         sat16 = 16'sh7fff;
         sat_hit = 1'b1;
      end else if (cmd < -64'sd32768) begin
         sat16 = 16'sh8000;
         sat_hit = 1'b1;
      end
   end

   // position increment with clamp to 24 bits
   always_comb begin
      rnd_v = rnd_shr(mul_p, 27);
      pos_sum = (op_ff == OP_XD) ? 64'(pos_x_ff) + rnd_v : 64'(pos_y_ff) + rnd_v;
      if (pos_sum > 64'sd8388607) pos_sum = 64'sd8388607;
      else if (pos_sum < -64'sd8388608) pos_sum = -64'sd8388608;
   end

   assign sum64 = t1_ff + mul_p;
   assign hsum = 64'(head_ff) + rnd_shr(mul_p, 16);

   always_comb begin
      state_in = state_ff;
      op_in = op_ff;
      lin_in = lin_ff;
      kgain_in = kgain_ff;
      base_in = base_ff;
      gain_in = gain_ff;
      dt_in = dt_ff;
      pos_x_in = pos_x_ff;
      pos_y_in = pos_y_ff;
      head_in = head_ff;
      idx_in = idx_ff;
      sn_in = sn_ff;
      cs_in = cs_ff;
      t1_in = t1_ff;
      proj_in = proj_ff;
      w_in = w_ff;
      vl_in = vl_ff;
      vr_in = vr_ff;
      lw_in = lw_ff;
      rw_in = rw_ff;
      clw_in = clw_ff;
      hmag_in = hmag_ff;
      hneg_in = hneg_ff;
      mul_go_in = 1'b0;
      div_go_in = 1'b0;
      rsp_valid_in = rsp_valid_ff;
      ro_left_in = ro_left_ff;
      ro_right_in = ro_right_ff;
      ro_clip_in = ro_clip_ff;

      if (rsp_valid_ff && rsp_port.ready) rsp_valid_in = 1'b0;

      // register writes must arrive only while idle; the block itself does not enforce this
      if (csr_we) begin
         case (csr_idx_type'(csr_index))
            CSR_LINEAR_SPEED: lin_in = csr_wdata;
            CSR_STEER_GAIN:   kgain_in = csr_wdata;
            CSR_WHEEL_BASE:   base_in = csr_wdata;
            CSR_PULSE_GAIN:   gain_in = csr_wdata;
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_port.valid) begin
               dt_in = req_port.step_time;
               clw_in = 1'b0;
               state_in = ST_IDXGO;
            end
         end
         ST_IDXGO: begin
            // table index = floor(heading * 2^bits / 2pi)
            div_go_in = 1'b1;
            state_in = ST_IDX;
         end
         ST_IDX: begin
            if (div_done) begin
               idx_in = div_quo[TB-1:0];
               state_in = ST_SIN;
            end
         end
         ST_SIN: state_in = ST_COS;
         ST_COS: begin
            sn_in = rom_val;
            state_in = ST_CSW;
         end
         ST_CSW: begin
            cs_in = rom_val;
            op_in = OP_DXC;
            mul_go_in = 1'b1;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            if (mul_done) begin
               mul_go_in = 1'b1;
               case (op_ff)
                  OP_DXC: begin t1_in = mul_p; op_in = OP_DYS; end
                  OP_DYS: begin proj_in = 28'(rnd_shr(sum64, 15)); op_in = OP_KP; end
                  OP_KP: begin
                     w_in = 34'((64'(lin_ff) <<< 4) + rnd_shr(mul_p, 12)) <<< 1;
                     op_in = OP_WB;
                  end
                  OP_WB: begin
                     vl_in = 35'(rnd_shr(v33 - mul_p, 17));
                     vr_in = 35'(rnd_shr(v33 + mul_p, 17));
                     op_in = OP_L1;
                  end
                  OP_L1: begin t1_in = mul_p; op_in = OP_L2; end
                  OP_L2: begin lw_in = sat16; clw_in = clw_ff | sat_hit; op_in = OP_R1; end
                  OP_R1: begin t1_in = mul_p; op_in = OP_R2; end
                  OP_R2: begin rw_in = sat16; clw_in = clw_ff | sat_hit; op_in = OP_XC; end
                  OP_XC: begin t1_in = mul_p; op_in = OP_XD; end
                  OP_XD: begin pos_x_in = pos_sum[23:0]; op_in = OP_YS; end
                  OP_YS: begin t1_in = mul_p; op_in = OP_YD; end
                  OP_YD: begin pos_y_in = pos_sum[23:0]; op_in = OP_WD; end
                  OP_WD: begin
                     // heading wrap by remainder of the magnitude
                     mul_go_in = 1'b0;
                     hneg_in = hsum[63];
                     hmag_in = hsum[63] ? 36'(-hsum) : hsum[35:0];
                     state_in = ST_MODGO;
                  end
                  default: mul_go_in = 1'b0;
               endcase
            end
         end
         ST_MODGO: begin
            div_go_in = 1'b1;
            state_in = ST_MOD;
         end
         ST_MOD: begin
            if (div_done) begin
               if (hneg_ff && div_rem != '0)
                  head_in = 20'(TWO_PI_Q16) - 20'(div_rem);
               else
                  head_in = 20'(div_rem);
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_port.ready) begin
               ro_left_in = lw_ff;
               ro_right_in = rw_ff;
               ro_clip_in = clw_ff;
               rsp_valid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      op_ff <= op_in;
      dt_ff <= dt_in;
      idx_ff <= idx_in;
      sn_ff <= sn_in;
      cs_ff <= cs_in;
      t1_ff <= t1_in;
      proj_ff <= proj_in;
      w_ff <= w_in;
      vl_ff <= vl_in;
      vr_ff <= vr_in;
      lw_ff <= lw_in;
      rw_ff <= rw_in;
      clw_ff <= clw_in;
      hmag_ff <= hmag_in;
      hneg_ff <= hneg_in;
      rom_ff <= qtab[rom_j];
      rom_neg_ff <= rom_idx[TB-1];
      ro_left_ff <= ro_left_in;
      ro_right_ff <= ro_right_in;
      ro_clip_ff <= ro_clip_in;
      if (reset) begin
         state_ff <= ST_IDLE;
         lin_ff <= 16'sd2048;
         kgain_ff <= 16'sd4096;
         base_ff <= 16'd6907;
         gain_ff <= 16'd6040;
         pos_x_ff <= '0;
         pos_y_ff <= '0;
         head_ff <= '0;
         mul_go_ff <= 1'b0;
         div_go_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         lin_ff <= lin_in;
         kgain_ff <= kgain_in;
         base_ff <= base_in;
         gain_ff <= gain_in;
         pos_x_ff <= pos_x_in;
         pos_y_ff <= pos_y_in;
         head_ff <= head_in;
         mul_go_ff <= mul_go_in;
         div_go_ff <= div_go_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_port.ready = (state_ff == ST_IDLE);
   assign rsp_port.valid = rsp_valid_ff;
   assign rsp_port.left_speed = ro_left_ff;
   assign rsp_port.right_speed = ro_right_ff;
   assign rsp_port.clipped = ro_clip_ff;
endmodule

/* sv/ddo_smul.sv */
// bit-serial signed multiplier, one multiplier bit per cycle
// depends on ddo_pkg
`timescale 1ns / 1ps
module ddo_smul
   import ddo_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      go,
   input  logic signed [MUL_A_W-1:0] a,
   input  logic signed [MUL_B_W-1:0] b,
   output logic                      done,
   output logic signed [MUL_P_W-1:0] p
);
   localparam int unsigned CNT_W = $clog2(MUL_B_W);

   logic signed [MUL_P_W-1:0] acc_ff, acc_in, ash_ff, ash_in, addend;
   logic [MUL_B_W-1:0] bsr_ff, bsr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in, done_ff, done_in;
   logic last;

   always_comb begin
      acc_in = acc_ff;
      ash_in = ash_ff;
      bsr_in = bsr_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      last = (cnt_ff == CNT_W'(MUL_B_W - 1));
      addend = bsr_ff[0] ? ash_ff : '0;
      if (go) begin
         acc_in = '0;
         ash_in = MUL_P_W'(a);
         bsr_in = b;
         cnt_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // sign bit of b carries negative weight
         acc_in = last ? acc_ff - addend : acc_ff + addend;
         ash_in = ash_ff <<< 1;
         bsr_in = bsr_ff >> 1;
         cnt_in = cnt_ff + 1'b1;
         if (last) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      ash_ff <= ash_in;
      bsr_ff <= bsr_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign p = acc_ff;
endmodule

/* sv/ddo_sdiv.sv */
// bit-serial restoring divider by the constant 2*pi in q16
// depends on ddo_pkg
`timescale 1ns / 1ps
module ddo_sdiv
   import ddo_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               go,
   input  logic [DIV_N_W-1:0] num,
   output logic               done,
   output logic [DIV_N_W-1:0] quo,
   output logic [DIV_R_W-1:0] rem
);
   localparam int unsigned CNT_W = $clog2(DIV_N_W);
   localparam logic [DIV_R_W:0] DIVISOR = (DIV_R_W+1)'(TWO_PI_Q16);

   logic [DIV_N_W-1:0] num_ff, num_in, quo_ff, quo_in;
   logic [DIV_R_W-1:0] rem_ff, rem_in;
   logic [DIV_R_W:0] trial;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in, done_ff, done_in;
   logic fits;

   always_comb begin
      num_in = num_ff;
      quo_in = quo_ff;
      rem_in = rem_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial = {rem_ff, num_ff[DIV_N_W-1]};
      fits = (trial >= DIVISOR);
      if (go) begin
         num_in = num;
         quo_in = '0;
         rem_in = '0;
         cnt_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? DIV_R_W'(trial - DIVISOR) : DIV_R_W'(trial);
         quo_in = {quo_ff[DIV_N_W-2:0], fits};
         num_in = num_ff << 1;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(DIV_N_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign quo = quo_ff;
   assign rem = rem_ff;
endmodule

/* sv/ddo_chk.sv */
// port-level checker for the odometry step core, bound to the top level
// depends on diff_drive_track_odometry_step_core_assert.svh
`timescale 1ns / 1ps
`include "diff_drive_track_odometry_step_core_assert.svh"
module ddo_chk (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic signed [15:0] left_speed,
   input logic signed [15:0] right_speed,
   input logic               clipped
);
   // response held while stalled
   `DDO_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(left_speed) && $stable(right_speed) && $stable(clipped))
   // one step in flight: busy right after a word is taken
   `DDO_ASSERT_NEXT(a_busy_after_take, clock, reset, req_valid && req_ready, !req_ready)
   // a flagged response must carry a rail value
   `DDO_ASSERT_NOW(a_clip_rail, clock, reset, rsp_valid && clipped, left_speed == 16'sh7fff || left_speed == 16'sh8000 || right_speed == 16'sh7fff || right_speed == 16'sh8000)
   // no response appears out of nowhere at the start of a busy spell
   `DDO_ASSERT_NEXT(a_no_spurious, clock, reset, !rsp_valid && !req_ready && req_ready == 1'b0 && $past(req_ready) == 1'b1, !rsp_valid)
endmodule

bind diff_drive_track_odometry_step_core ddo_chk u_ddo_chk (
   .clock(clock), .reset(reset),
   .req_valid(req_port.valid), .req_ready(req_port.ready),
   .rsp_valid(rsp_port.valid), .rsp_ready(rsp_port.ready),
   .left_speed(rsp_port.left_speed), .right_speed(rsp_port.right_speed),
   .clipped(rsp_port.clipped)
);

/* tb/tb.sv */
// testbench for the differential drive odometry step core
// depends on ddo_pkg, ddo_chan_if and the core; predicts each wheel word from its own pose model
`timescale 1ns / 1ps
module tb
   import ddo_pkg::*;
();

   localparam int unsigned LUT_BITS = 10;
   localparam int unsigned LUT_N = 1 << LUT_BITS;
   localparam longint TURN_Q16 = 411775;
   localparam longint QUARTER_TURN_Q30 = 64'd1686629713;
   localparam int unsigned DRAIN_CYCLES = 600;

   typedef struct {
      logic signed [15:0] left_speed;
      logic signed [15:0] right_speed;
      logic               clipped;
   } wheel_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [1:0] csr_index = CSR_LINEAR_SPEED;
   logic [15:0] csr_wdata = '0;

   ddo_req_if req_if ();
   ddo_rsp_if rsp_if ();

   diff_drive_track_odometry_step_core u_top (
      .clock     (clock),
      .reset     (reset),
      .req_port  (req_if),
      .rsp_port  (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   // predictor state: registers, pose and sine table
   logic signed [15:0] cfg_speed;
   logic signed [15:0] cfg_gain_k;
   logic [15:0]        cfg_base;
   logic [15:0]        cfg_pulse;
   longint             pose_x, pose_y, pose_th;
   longint             sine_lut [LUT_N];

   wheel_word_type wheel_word_q [$];
   int errors = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_off_cycles = 0;

   // round to nearest, ties toward +inf
   function automatic longint round_shift(longint x, int unsigned n);
      return (x + (64'sd1 <<< (n - 1))) >>> n;
   endfunction

   function automatic longint sat_range(longint x, longint lo, longint hi);
      return x < lo ? lo : (x > hi ? hi : x);
   endfunction

   // sine of j quarter-turn steps out of q, q1.15, series in q30
   function automatic longint quarter_wave(longint unsigned j, longint unsigned q);
      longint unsigned ang, ang2, term;
      longint acc;
      ang = j * QUARTER_TURN_Q30 / q;
      ang2 = (ang * ang) >> 30;
      term = ang;
      acc = longint'(ang);
      for (int n = 1; n <= 6; n++) begin
         term = ((term * ang2) >> 30) / longint'((2 * n) * (2 * n + 1));
         if (n % 2 == 1) acc -= longint'(term);
         else acc += longint'(term);
      end
      acc = sat_range(acc, 0, 64'sd1 <<< 30);
      return (acc + 16384) >>> 15;
   endfunction

   function automatic void fill_sine_lut();
      longint unsigned q, quad, r;
      q = LUT_N / 4;
      for (int i = 0; i < LUT_N; i++) begin
         quad = i / q;
         r = i % q;
         case (quad)
            0: sine_lut[i] = quarter_wave(r, q);
            1: sine_lut[i] = quarter_wave(q - r, q);
            2: sine_lut[i] = -quarter_wave(r, q);
            default: sine_lut[i] = -quarter_wave(q - r, q);
         endcase
      end
   endfunction

   function automatic longint wheel_pulses(longint vel_q33, longint gain, ref logic clip);
      longint cmd;
      cmd = round_shift(round_shift(vel_q33, 17) * 1000 * gain, 28);
      if (cmd > 32767) begin
         clip = 1'b1;
         return 32767;
      end
      if (cmd < -32768) begin
         clip = 1'b1;
         return -32768;
      end
      return cmd;
   endfunction

   // one control step: wheel command from the old pose, then integrate
   function automatic wheel_word_type predict_step(logic [15:0] step_time);
      wheel_word_type res;
      longint v, k, base, gain, dt, idx, sn, cs, proj, w, wb, v33, th;
      logic clip;
      v = longint'(cfg_speed);
      k = longint'(cfg_gain_k);
      base = longint'({1'b0, cfg_base});
      gain = longint'({1'b0, cfg_pulse});
      dt = longint'({1'b0, step_time});
      clip = 1'b0;
      idx = ((pose_th <<< LUT_BITS) / TURN_Q16) & (LUT_N - 1);
      sn = sine_lut[idx];
      cs = sine_lut[(idx + LUT_N / 4) & (LUT_N - 1)];
      proj = round_shift((pose_x - 65536) * cs + (pose_y - 65536) * sn, 15);
      w = 2 * (v * 16 + round_shift(k * proj, 12));
      wb = w * base;
      v33 = v * (64'sd1 <<< 21);
      res.left_speed = 16'(wheel_pulses(v33 - wb, gain, clip));
      res.right_speed = 16'(wheel_pulses(v33 + wb, gain, clip));
      res.clipped = clip;
      pose_x = sat_range(pose_x + round_shift(v * cs * dt, 27), -8388608, 8388607);
      pose_y = sat_range(pose_y + round_shift(v * sn * dt, 27), -8388608, 8388607);
      th = (pose_th + round_shift(w * dt, 16)) % TURN_Q16;
      if (th < 0) th += TURN_Q16;
      pose_th = th;
      return res;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      errors++;
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
   endtask

   // response side: random ready, long hold-off counted here
   always @(negedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else if (hold_off_cycles > 0) begin
         rsp_if.ready <= 1'b0;
         hold_off_cycles <= hold_off_cycles - 1;
      end else begin
         rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // compare each accepted word with the oldest prediction
   always @(posedge clock) begin
      wheel_word_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (wheel_word_q.size() == 0) begin
            errors++;
            $display("unexpected wheel word at %0t", $time);
         end else begin
            want = wheel_word_q.pop_front();
            if (rsp_if.left_speed !== want.left_speed)
               report_mismatch("left_speed", rsp_if.left_speed, want.left_speed);
            if (rsp_if.right_speed !== want.right_speed)
               report_mismatch("right_speed", rsp_if.right_speed, want.right_speed);
            if (rsp_if.clipped !== want.clipped)
               report_mismatch("clipped", rsp_if.clipped, want.clipped);
         end
      end
   end

   // send one step word; entered and left at a falling edge, valid stays high
   task automatic send_step(logic [15:0] step_time);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.step_time <= step_time;
      do @(posedge clock); while (!req_if.ready);
      wheel_word_q.push_back(predict_step(step_time));
      @(negedge clock);
   endtask

   // stop sending, wait for every word, then let the sequencer finish
   task automatic wait_idle();
      req_if.valid <= 1'b0;
      while (wheel_word_q.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // write all four registers back to back; only while idle
   task automatic write_regs(logic [15:0] v, logic [15:0] k, logic [15:0] b, logic [15:0] g);
      csr_we <= 1'b1;
      csr_index <= CSR_LINEAR_SPEED;
      csr_wdata <= v;
      @(negedge clock);
      csr_index <= CSR_STEER_GAIN;
      csr_wdata <= k;
      @(negedge clock);
      csr_index <= CSR_WHEEL_BASE;
      csr_wdata <= b;
      @(negedge clock);
      csr_index <= CSR_PULSE_GAIN;
      csr_wdata <= g;
      @(negedge clock);
      csr_we <= 1'b0;
      cfg_speed = v;
      cfg_gain_k = k;
      cfg_base = b;
      cfg_pulse = g;
   endtask

   function automatic logic [15:0] rand_step_time();
      case ($urandom_range(3))
         0: return 16'($urandom_range(255));
         1: return 16'($urandom_range(4095));
         default: return 16'($urandom);
      endcase
   endfunction

   // reset defaults, step time extremes and single bits
   task automatic test_default_regs();
      send_step(16'h0000);
      send_step(16'hffff);
      send_step(16'h0001);
      send_step(16'h8000);
      for (int b = 0; b < 16; b += 3) send_step(16'h1 << b);
      send_step(16'h5555);
      send_step(16'haaaa);
      wait_idle();
   endtask

   // register extremes: wheel saturation, pose saturation, heading wrap both ways
   task automatic test_reg_extremes();
      write_regs(16'h7fff, 16'h7fff, 16'hffff, 16'hffff);
      repeat (5) send_step(16'hffff);
      wait_idle();
      write_regs(16'h8000, 16'h8000, 16'h0000, 16'h0000);
      repeat (5) send_step(16'hffff);
      wait_idle();
      write_regs(16'h8000, 16'h7fff, 16'h8000, 16'h1000);
      repeat (4) send_step(16'hc000);
      wait_idle();
      write_regs(16'h7fff, 16'h8000, 16'hffff, 16'h0001);
      repeat (4) send_step(16'hc000);
      wait_idle();
   endtask

   // random words under one idling mode, registers changed between bursts
   task automatic test_random_mode(int s_pct, int r_pct, int n_words);
      send_idle_pct = s_pct;
      recv_idle_pct = r_pct;
      for (int i = 0; i < n_words; i++) begin
         if (i % 50 == 0) begin
            wait_idle();
            if ($urandom_range(4) == 0)
               write_regs(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
            else
               write_regs(16'($signed($urandom_range(8191)) - 4096),
                          16'($signed($urandom_range(16383)) - 8192),
                          16'($urandom_range(16383)), 16'($urandom_range(8191)));
         end
         send_step(rand_step_time());
      end
      wait_idle();
   endtask

   // long receiver hold-off with the sender still offering, so the input stalls
   task automatic test_backpressure();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_off_cycles = 2000;
      repeat (8) send_step(rand_step_time());
      wait_idle();
   endtask

   initial begin
      req_if.valid = 1'b0;
      req_if.step_time = '0;
      rsp_if.ready = 1'b0;
      cfg_speed = 16'sd2048;
      cfg_gain_k = 16'sd4096;
      cfg_base = 16'd6907;
      cfg_pulse = 16'd6040;
      pose_x = 0;
      pose_y = 0;
      pose_th = 0;
      fill_sine_lut();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_default_regs();
      test_reg_extremes();
      test_random_mode(31, 49, 200);
      test_random_mode(49, 31, 200);
      test_random_mode(0, 0, 200);
      test_backpressure();

      if (errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // about 650 words plus stalls, taken several times over
   initial begin
      #20_000_000;
      $display("TB_ERROR");
      $finish;
   end

endmodule
